// File: hdl/cdas_pkg.sv
// shared types, constants and calendar helper functions for the date engine
package cdas_pkg;

    // field widths of the item ports
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 16;
    localparam int DIFF_W  = 23;
    localparam int OP_W    = 2;

    // internal widths
    localparam int ACC_W  = 25;
    localparam int YR_W   = 18;
    localparam int REM_W  = 15;
    localparam int Q_W    = 6;
    localparam int R400_W = 9;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 2'd1;
    localparam logic [OP_W-1:0] OP_DIFF = 2'd2;
    localparam logic [OP_W-1:0] OP_CMP  = 2'd3;

    // calendar constants
    localparam logic [REM_W-1:0]   ERA_YEARS  = 15'd400;
    localparam logic [REM_W-1:0]   YEAR_SHIFT = 15'd400;
    localparam logic [R400_W-1:0]  ERA_LAST   = 9'd399;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic signed [ACC_W-1:0] DIFF_MAX = 25'sd4194303;
    localparam logic signed [ACC_W-1:0] DIFF_MIN = -25'sd4194304;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_DIV,
        ST_OFS,
        ST_WALK,
        ST_SUM,
        ST_FIN
    } state_t;

    // terms of the day-number sum, one per adder pass
    typedef enum logic [3:0] {
        TRM_Y256,
        TRM_Y64,
        TRM_Y32,
        TRM_Y8,
        TRM_Y4,
        TRM_Y1,
        TRM_YQ4,
        TRM_YC100,
        TRM_YQ400,
        TRM_MD
    } term_t;

    // sequencer to datapath
    typedef struct packed {
        logic  capture;
        logic  init;
        logic  div;
        logic  ofs;
        logic  walk;
        logic  sum;
        logic  second;
        term_t term;
        logic  fin_load;
    } ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            div_more;
        logic            walk_done;
    } stat_t;

    // month 0 reads as january, 13..15 as december
    function automatic logic [MONTH_W-1:0] month_clamp(input logic [MONTH_W-1:0] m);
        logic [MONTH_W-1:0] r;
        r = m;
        if (m < MONTH_JAN) begin
            r = MONTH_JAN;
        end else if (m > MONTH_DEC) begin
            r = MONTH_DEC;
        end
        return r;
    endfunction

    // leap rule on the year modulo 400
    function automatic logic is_leap(input logic [R400_W-1:0] r);
        return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
    endfunction

    // whole centuries within the 400-year cycle
    function automatic logic [1:0] century(input logic [R400_W-1:0] r);
        logic [1:0] c;
        priority if (r >= 9'd300) begin
            c = 2'd3;
        end else if (r >= 9'd200) begin
            c = 2'd2;
        end else if (r >= 9'd100) begin
            c = 2'd1;
        end else begin
            c = 2'd0;
        end
        return c;
    endfunction

    // days in a month
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // days from march 1 to the first of the month, year starting in march
    function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
        logic [8:0] s;
        unique case (m)
            4'd3:    s = 9'd0;
            4'd4:    s = 9'd31;
            4'd5:    s = 9'd61;
            4'd6:    s = 9'd92;
            4'd7:    s = 9'd122;
            4'd8:    s = 9'd153;
            4'd9:    s = 9'd184;
            4'd10:   s = 9'd214;
            4'd11:   s = 9'd245;
            4'd12:   s = 9'd275;
            4'd1:    s = 9'd306;
            4'd2:    s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

// File: hdl/cdas_alu.sv
// shared add/subtract unit used by the division, offset, walk and sum steps of the sequencer
module cdas_alu #(
    parameter int W = 25
) (
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    input  logic                sub,
    output logic signed [W-1:0] sum
);

    // subtract as add of the inverted operand plus carry in
    assign sum = a + (b ^ {W{sub}}) + W'(sub);

endmodule

// File: hdl/cdas_ctrl.sv
// sequencer of the date engine: handshakes, step order and term counter
module cdas_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  cdas_pkg::stat_t stat,
    output cdas_pkg::ctrl_t ctl
);
    import cdas_pkg::*;

    state_t state_reg, state_next;
    logic   second_reg, second_next;
    term_t  term_reg, term_next;
    logic   m_valid_reg, m_valid_next;
    logic   fin_load;

    // next state and step counters
    always_comb begin
        state_next  = state_reg;
        second_next = second_reg;
        term_next   = term_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next  = ST_INIT;
                    second_next = 1'b0;
                end
            end
            ST_INIT: begin
                state_next = (stat.op == OP_CMP) ? ST_FIN : ST_DIV;
            end
            ST_DIV: begin
                if (!stat.div_more) begin
                    state_next = (stat.op == OP_DIFF) ? ST_SUM : ST_OFS;
                    term_next  = TRM_Y256;
                end
            end
            ST_OFS: begin
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (stat.walk_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_SUM: begin
                if (term_reg == TRM_MD) begin
                    state_next  = second_reg ? ST_FIN : ST_INIT;
                    second_next = 1'b1;
                end else begin
                    term_next = term_t'(term_reg + 4'd1);
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // controls to the datapath
    always_comb begin
        fin_load     = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);
        ctl          = '0;
        ctl.capture  = (state_reg == ST_IDLE) && s_valid;
        ctl.init     = (state_reg == ST_INIT);
        ctl.div      = (state_reg == ST_DIV);
        ctl.ofs      = (state_reg == ST_OFS);
        ctl.walk     = (state_reg == ST_WALK);
        ctl.sum      = (state_reg == ST_SUM);
        ctl.second   = second_reg;
        ctl.term     = term_reg;
        ctl.fin_load = fin_load;
        s_ready      = (state_reg == ST_IDLE);
        m_valid      = m_valid_reg;
    end

    // result valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (fin_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            second_reg  <= 1'b0;
            term_reg    <= TRM_Y256;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            second_reg  <= second_next;
            term_reg    <= term_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // an accepted item keeps the input closed on the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input still open after an item was accepted");

    // a finished result waits while the output register is still held
    a_fin_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) && m_valid_reg && !m_ready |=> (state_reg == ST_FIN))
        else $error("result overwrote an item not yet taken");

    // results appear only out of the finishing step
    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("result valid raised outside the finishing step");

endmodule

// File: hdl/cdas_dp.sv
// datapath of the date engine: item registers, shared adder, month walk and result registers
module cdas_dp #(
    parameter int unsigned YEAR_MAX = 9999
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  cdas_pkg::ctrl_t                     ctl,
    output cdas_pkg::stat_t                     stat,
    input  logic [cdas_pkg::OP_W-1:0]           in_op,
    input  logic [cdas_pkg::YEAR_W-1:0]         in_first_year,
    input  logic [cdas_pkg::MONTH_W-1:0]        in_first_month,
    input  logic [cdas_pkg::DAY_W-1:0]          in_first_day,
    input  logic [cdas_pkg::YEAR_W-1:0]         in_second_year,
    input  logic [cdas_pkg::MONTH_W-1:0]        in_second_month,
    input  logic [cdas_pkg::DAY_W-1:0]          in_second_day,
    input  logic signed [cdas_pkg::COUNT_W-1:0] in_day_count,
    output logic [cdas_pkg::YEAR_W-1:0]         res_year,
    output logic [cdas_pkg::MONTH_W-1:0]        res_month,
    output logic [cdas_pkg::DAY_W-1:0]          res_day,
    output logic signed [cdas_pkg::DIFF_W-1:0]  res_diff,
    output logic                                res_less,
    output logic                                res_equal,
    output logic                                res_oor
);
    import cdas_pkg::*;

    localparam logic signed [YR_W-1:0] YearMaxS = YR_W'(YEAR_MAX);

    // item registers
    logic [OP_W-1:0]           op_reg;
    logic [YEAR_W-1:0]         fy_reg, sy_reg;
    logic [MONTH_W-1:0]        fm_reg, sm_reg;
    logic [DAY_W-1:0]          fd_reg, sd_reg;
    logic signed [COUNT_W-1:0] cnt_reg;

    // working registers
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [Q_W-1:0]            q_reg, q_next;
    logic signed [YR_W-1:0]    year_reg, year_next;
    logic [MONTH_W-1:0]        month_reg, month_next;

    // result registers
    logic [YEAR_W-1:0]         res_year_reg, res_year_next;
    logic [MONTH_W-1:0]        res_month_reg, res_month_next;
    logic [DAY_W-1:0]          res_day_reg, res_day_next;
    logic signed [DIFF_W-1:0]  res_diff_reg, res_diff_next;
    logic                      res_less_reg, res_less_next;
    logic                      res_equal_reg, res_equal_next;
    logic                      res_oor_reg, res_oor_next;

    logic [YEAR_W-1:0]         sel_y;
    logic [MONTH_W-1:0]        sel_m;
    logic [DAY_W-1:0]          sel_d;
    logic [REM_W-1:0]          yy;
    logic signed [ACC_W-1:0]   yy_e;
    logic signed [9:0]         msd;
    logic [R400_W-1:0]         r400, r400_inc, r400_dec;
    logic                      leap;
    logic [MONTH_W-1:0]        m_prev;
    logic [DAY_W-1:0]          len_f, len_b;
    logic                      acc_neg;
    logic signed [ACC_W-1:0]   term_val;
    logic                      term_neg;
    logic signed [ACC_W-1:0]   alu_a, alu_b, alu_sum;
    logic                      alu_sub;

    // capture of the accepted item
    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            op_reg  <= in_op;
            fy_reg  <= in_first_year;
            fm_reg  <= in_first_month;
            fd_reg  <= in_first_day;
            sy_reg  <= in_second_year;
            sm_reg  <= in_second_month;
            sd_reg  <= in_second_day;
            cnt_reg <= in_day_count;
        end
    end

    // date under work and its shifted year (march-based for the day number)
    always_comb begin
        sel_y = ctl.second ? sy_reg : fy_reg;
        sel_m = month_clamp(ctl.second ? sm_reg : fm_reg);
        sel_d = ctl.second ? sd_reg : fd_reg;
        if (op_reg == OP_DIFF) begin
            yy = REM_W'(sel_y) + YEAR_SHIFT - REM_W'(sel_m <= MONTH_FEB);
        end else begin
            yy = REM_W'(sel_y);
        end
        yy_e = ACC_W'(yy);
        msd  = signed'(10'(month_start(sel_m)) + 10'(sel_d) - 10'd1);
    end

    // calendar position of the walk
    always_comb begin
        r400     = rem_reg[R400_W-1:0];
        r400_inc = (r400 == ERA_LAST) ? '0 : r400 + 9'd1;
        r400_dec = (r400 == '0) ? ERA_LAST : r400 - 9'd1;
        leap     = is_leap(r400);
        m_prev   = (month_reg == MONTH_JAN) ? MONTH_DEC : month_reg - 4'd1;
        len_f    = month_len(month_reg, leap);
        len_b    = month_len(m_prev, leap);
        acc_neg  = acc_reg[ACC_W-1];
    end

    // terms of 365*yy + yy/4 - yy/100 + yy/400 + month start + day - 1
    always_comb begin
        term_neg = 1'b0;
        unique case (ctl.term)
            TRM_Y256:  term_val = yy_e <<< 8;
            TRM_Y64:   term_val = yy_e <<< 6;
            TRM_Y32:   term_val = yy_e <<< 5;
            TRM_Y8:    term_val = yy_e <<< 3;
            TRM_Y4:    term_val = yy_e <<< 2;
            TRM_Y1:    term_val = yy_e;
            TRM_YQ4:   term_val = yy_e >>> 2;
            TRM_YC100: begin
                term_val = ACC_W'({q_reg, 2'b00}) + ACC_W'(century(r400));
                term_neg = 1'b1;
            end
            TRM_YQ400: term_val = ACC_W'(q_reg);
            TRM_MD:    term_val = ACC_W'(msd);
            default:   term_val = '0;
        endcase
    end

    // operand selection for the shared adder
    always_comb begin
        unique if (ctl.div) begin
            alu_a   = ACC_W'(rem_reg);
            alu_b   = ACC_W'(ERA_YEARS);
            alu_sub = 1'b1;
        end else if (ctl.ofs) begin
            alu_a   = acc_reg;
            alu_b   = ACC_W'(cnt_reg);
            alu_sub = (op_reg == OP_SUB);
        end else if (ctl.walk) begin
            alu_a   = acc_reg;
            alu_b   = ACC_W'(acc_neg ? len_b : len_f);
            alu_sub = !acc_neg;
        end else begin
            alu_a   = acc_reg;
            alu_b   = term_val;
            alu_sub = term_neg ^ ctl.second;
        end
    end

    cdas_alu #(
        .W (ACC_W)
    ) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum)
    );

    // status to the sequencer
    always_comb begin
        stat.op        = op_reg;
        stat.div_more  = !alu_sum[ACC_W-1];
        stat.walk_done = !acc_neg && alu_sum[ACC_W-1];
    end

    // working register updates
    always_comb begin
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        year_next  = year_reg;
        month_next = month_reg;
        if (ctl.init) begin
            rem_next = yy;
            q_next   = '0;
            if (op_reg != OP_DIFF) begin
                acc_next   = ACC_W'(fd_reg) - ACC_W'(1);
                year_next  = YR_W'(fy_reg);
                month_next = month_clamp(fm_reg);
            end else if (!ctl.second) begin
                acc_next = '0;
            end
        end
        // repeated subtraction of 400 years
        if (ctl.div && stat.div_more) begin
            rem_next = alu_sum[REM_W-1:0];
            q_next   = q_reg + Q_W'(1);
        end
        if (ctl.ofs || ctl.sum) begin
            acc_next = alu_sum;
        end
        // one month per step, back while negative, forward while a month fits
        if (ctl.walk) begin
            if (acc_neg) begin
                acc_next   = alu_sum;
                month_next = m_prev;
                if (month_reg == MONTH_JAN) begin
                    year_next = year_reg - YR_W'(1);
                    rem_next  = REM_W'(r400_dec);
                end
            end else if (!alu_sum[ACC_W-1]) begin
                acc_next = alu_sum;
                if (month_reg == MONTH_DEC) begin
                    month_next = MONTH_JAN;
                    year_next  = year_reg + YR_W'(1);
                    rem_next   = REM_W'(r400_inc);
                end else begin
                    month_next = month_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        year_reg  <= year_next;
        month_reg <= month_next;
    end

    // result formation with range clamps
    always_comb begin
        res_year_next  = '0;
        res_month_next = '0;
        res_day_next   = '0;
        res_diff_next  = '0;
        res_less_next  = 1'b0;
        res_equal_next = 1'b0;
        res_oor_next   = 1'b0;
        unique case (op_reg)
            OP_ADD, OP_SUB: begin
                if (year_reg < 0) begin
                    res_month_next = MONTH_JAN;
                    res_day_next   = 5'd1;
                    res_oor_next   = 1'b1;
                end else if (year_reg > YearMaxS) begin
                    res_year_next  = YearMaxS[YEAR_W-1:0];
                    res_month_next = MONTH_DEC;
                    res_day_next   = 5'd31;
                    res_oor_next   = 1'b1;
                end else begin
                    res_year_next  = year_reg[YEAR_W-1:0];
                    res_month_next = month_reg;
                    res_day_next   = acc_reg[DAY_W-1:0] + 5'd1;
                end
            end
            OP_DIFF: begin
                if (acc_reg > DIFF_MAX) begin
                    res_diff_next = DIFF_MAX[DIFF_W-1:0];
                    res_oor_next  = 1'b1;
                end else if (acc_reg < DIFF_MIN) begin
                    res_diff_next = DIFF_MIN[DIFF_W-1:0];
                    res_oor_next  = 1'b1;
                end else begin
                    res_diff_next = acc_reg[DIFF_W-1:0];
                end
            end
            OP_CMP: begin
                res_less_next  = {fy_reg, fm_reg, fd_reg} < {sy_reg, sm_reg, sd_reg};
                res_equal_next = {fy_reg, fm_reg, fd_reg} == {sy_reg, sm_reg, sd_reg};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.fin_load) begin
            res_year_reg  <= res_year_next;
            res_month_reg <= res_month_next;
            res_day_reg   <= res_day_next;
            res_diff_reg  <= res_diff_next;
            res_less_reg  <= res_less_next;
            res_equal_reg <= res_equal_next;
            res_oor_reg   <= res_oor_next;
        end
    end

    assign res_year  = res_year_reg;
    assign res_month = res_month_reg;
    assign res_day   = res_day_reg;
    assign res_diff  = res_diff_reg;
    assign res_less  = res_less_reg;
    assign res_equal = res_equal_reg;
    assign res_oor   = res_oor_reg;

    // the walk only ever sees a real month
    a_walk_month: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.walk |-> (month_reg >= MONTH_JAN) && (month_reg <= MONTH_DEC))
        else $error("month left 1..12 during the walk");

    // year-in-cycle tracking stays below 400 through every carry
    a_walk_era: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.walk |-> (rem_reg < ERA_YEARS))
        else $error("year modulo 400 out of range during the walk");

    // the walk ends with an offset inside the month
    a_walk_end: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.walk && stat.walk_done |-> (acc_reg >= 0) && (acc_reg < 31))
        else $error("walk ended with a day offset outside the month");

endmodule

// File: hdl/calendar_date_add_sub_diff.sv
// top level of the gregorian date engine: add/subtract days, day difference, compare
//
// channel | handshake         | carries
// --------+-------------------+-------------------------------------------------
// s_      | s_valid / s_ready | op, first date, second date, day_count
// m_      | m_valid / m_ready | result date, day_difference, less/equal, range
//
// compare goes from accept through the init step and the finishing step to the output register
// difference runs two 400-year reductions and ten adder passes per date on the one shared adder
// add/subtract runs a 400-year reduction, the day-count offset and then the
// month-by-month walk, all on the shared adder
// one item at a time; s_ready is high only when idle, and a finished result may sit in
// the output register while the next item is taken
// aresetn is synchronous and clears only control state
module calendar_date_add_sub_diff #(
    parameter int unsigned YEAR_MAX = 9999
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [cdas_pkg::OP_W-1:0]           s_op,
    input  logic [cdas_pkg::YEAR_W-1:0]         s_first_year,
    input  logic [cdas_pkg::MONTH_W-1:0]        s_first_month,
    input  logic [cdas_pkg::DAY_W-1:0]          s_first_day,
    input  logic [cdas_pkg::YEAR_W-1:0]         s_second_year,
    input  logic [cdas_pkg::MONTH_W-1:0]        s_second_month,
    input  logic [cdas_pkg::DAY_W-1:0]          s_second_day,
    input  logic signed [cdas_pkg::COUNT_W-1:0] s_day_count,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [cdas_pkg::YEAR_W-1:0]         m_result_year,
    output logic [cdas_pkg::MONTH_W-1:0]        m_result_month,
    output logic [cdas_pkg::DAY_W-1:0]          m_result_day,
    output logic signed [cdas_pkg::DIFF_W-1:0]  m_day_difference,
    output logic                                m_is_less,
    output logic                                m_is_equal,
    output logic                                m_out_of_range
);
    import cdas_pkg::*;

    ctrl_t ctl;
    stat_t stat;

    // sequencer
    cdas_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctl     (ctl)
    );

    // datapath with the shared adder
    cdas_dp #(
        .YEAR_MAX (YEAR_MAX)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctl             (ctl),
        .stat            (stat),
        .in_op           (s_op),
        .in_first_year   (s_first_year),
        .in_first_month  (s_first_month),
        .in_first_day    (s_first_day),
        .in_second_year  (s_second_year),
        .in_second_month (s_second_month),
        .in_second_day   (s_second_day),
        .in_day_count    (s_day_count),
        .res_year        (m_result_year),
        .res_month       (m_result_month),
        .res_day         (m_result_day),
        .res_diff        (m_day_difference),
        .res_less        (m_is_less),
        .res_equal       (m_is_equal),
        .res_oor         (m_out_of_range)
    );

endmodule

// File: tb/sv/tb_calendar_date_add_sub_diff.sv
// self-checking testbench for the calendar date engine: add, subtract, difference, compare
`timescale 1ns / 100ps

module tb_calendar_date_add_sub_diff;
    import cdas_pkg::*;

    localparam int unsigned MAX_YEAR     = 9999;
    localparam longint      SHIFT_YEARS  = 400;
    localparam longint      DAYS_PER_ERA = 146097;
    localparam int unsigned RANDOM_ITEMS = 266;
    localparam int unsigned DRAIN_CYCLES = 1500;
    localparam int unsigned CYCLE_LIMIT  = 1500000;

    // one request to the engine
    typedef struct {
        logic [OP_W-1:0]           op;
        logic [YEAR_W-1:0]         first_year;
        logic [MONTH_W-1:0]        first_month;
        logic [DAY_W-1:0]          first_day;
        logic [YEAR_W-1:0]         second_year;
        logic [MONTH_W-1:0]        second_month;
        logic [DAY_W-1:0]          second_day;
        logic signed [COUNT_W-1:0] day_count;
    } date_request_t;

    // one answer from the engine
    typedef struct {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [DIFF_W-1:0]  diff;
        logic               less;
        logic               equal;
        logic               range_err;
    } date_result_t;

    logic                      aclk;
    logic                      aresetn          = 1'b0;
    logic                      s_valid          = 1'b0;
    logic                      s_ready;
    logic [OP_W-1:0]           s_op             = '0;
    logic [YEAR_W-1:0]         s_first_year     = '0;
    logic [MONTH_W-1:0]        s_first_month    = '0;
    logic [DAY_W-1:0]          s_first_day      = '0;
    logic [YEAR_W-1:0]         s_second_year    = '0;
    logic [MONTH_W-1:0]        s_second_month   = '0;
    logic [DAY_W-1:0]          s_second_day     = '0;
    logic signed [COUNT_W-1:0] s_day_count      = '0;
    logic                      m_valid;
    logic                      m_ready          = 1'b0;
    logic [YEAR_W-1:0]         m_result_year;
    logic [MONTH_W-1:0]        m_result_month;
    logic [DAY_W-1:0]          m_result_day;
    logic signed [DIFF_W-1:0]  m_day_difference;
    logic                      m_is_less;
    logic                      m_is_equal;
    logic                      m_out_of_range;

    date_request_t request_q[$];
    date_result_t  awaited_dates[$];
    date_request_t drive_item;
    int unsigned   total_requests = 0;
    int unsigned   accepted_count = 0;
    int unsigned   fail_count     = 0;
    int unsigned   cycle_count    = 0;
    int unsigned   burst_left     = 0;
    int unsigned   gap_left       = 0;
    int unsigned   ready_left     = 0;
    int unsigned   stall_left     = 0;

    calendar_date_add_sub_diff #(
        .YEAR_MAX(MAX_YEAR)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op(s_op),
        .s_first_year(s_first_year),
        .s_first_month(s_first_month),
        .s_first_day(s_first_day),
        .s_second_year(s_second_year),
        .s_second_month(s_second_month),
        .s_second_day(s_second_day),
        .s_day_count(s_day_count),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_result_year(m_result_year),
        .m_result_month(m_result_month),
        .m_result_day(m_result_day),
        .m_day_difference(m_day_difference),
        .m_is_less(m_is_less),
        .m_is_equal(m_is_equal),
        .m_out_of_range(m_out_of_range)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // day count from march 1 of year -400, after month clamping
    function automatic longint day_number(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                                          logic [DAY_W-1:0] d);
        longint yy;
        longint mm;
        longint dd;
        longint mar;
        yy = y;
        mm = m;
        dd = d;
        yy = yy + SHIFT_YEARS;
        if (mm < 1) begin
            mm = 1;
        end
        if (mm > 12) begin
            mm = 12;
        end
        if (mm <= 2) begin
            yy = yy - 1;
        end
        mar = (mm + 9) % 12;
        return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mar + 2) / 5 + dd - 1;
    endfunction

    // calendar date back from a day count, year without the shift
    function automatic void date_of_day_number(input longint z, output longint y,
                                               output longint m, output longint d);
        longint era;
        longint doe;
        longint yoe;
        longint doy;
        longint mar;
        era = z / DAYS_PER_ERA;
        doe = z - era * DAYS_PER_ERA;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mar = (5 * doy + 2) / 153;
        m   = (mar < 10) ? mar + 3 : mar - 9;
        d   = doy - (153 * mar + 2) / 5 + 1;
        y   = yoe + era * 400 + ((m <= 2) ? 1 : 0) - SHIFT_YEARS;
    endfunction

    // expected answer of the engine for one request
    function automatic date_result_t engine_answer(date_request_t rq);
        date_result_t r;
        longint       z;
        longint       y;
        longint       m;
        longint       d;
        longint       df;
        longint       delta;
        r     = '{default: '0};
        delta = rq.day_count;
        case (rq.op)
            OP_ADD, OP_SUB: begin
                z = day_number(rq.first_year, rq.first_month, rq.first_day);
                z = (rq.op == OP_ADD) ? z + delta : z - delta;
                date_of_day_number(z, y, m, d);
                if (y < 0) begin
                    y = 0;
                    m = 1;
                    d = 1;
                    r.range_err = 1'b1;
                end else if (y > MAX_YEAR) begin
                    y = MAX_YEAR;
                    m = 12;
                    d = 31;
                    r.range_err = 1'b1;
                end
                r.year  = y[YEAR_W-1:0];
                r.month = m[MONTH_W-1:0];
                r.day   = d[DAY_W-1:0];
            end
            OP_DIFF: begin
                df = day_number(rq.first_year, rq.first_month, rq.first_day)
                   - day_number(rq.second_year, rq.second_month, rq.second_day);
                if (df > DIFF_MAX) begin
                    df = DIFF_MAX;
                    r.range_err = 1'b1;
                end
                if (df < DIFF_MIN) begin
                    df = DIFF_MIN;
                    r.range_err = 1'b1;
                end
                r.diff = df[DIFF_W-1:0];
            end
            default: begin
                // raw field comparison, no clamping
                if (rq.first_year < rq.second_year) begin
                    r.less = 1'b1;
                end else if (rq.first_year == rq.second_year
                             && rq.first_month < rq.second_month) begin
                    r.less = 1'b1;
                end else if (rq.first_year == rq.second_year
                             && rq.first_month == rq.second_month
                             && rq.first_day < rq.second_day) begin
                    r.less = 1'b1;
                end
                r.equal = (rq.first_year == rq.second_year
                           && rq.first_month == rq.second_month
                           && rq.first_day == rq.second_day);
            end
        endcase
        return r;
    endfunction

    function automatic void add_request(logic [OP_W-1:0] op,
                                        logic [YEAR_W-1:0] fy, logic [MONTH_W-1:0] fm,
                                        logic [DAY_W-1:0] fd,
                                        logic [YEAR_W-1:0] sy, logic [MONTH_W-1:0] sm,
                                        logic [DAY_W-1:0] sd,
                                        logic signed [COUNT_W-1:0] cnt);
        date_request_t rq;
        rq.op           = op;
        rq.first_year   = fy;
        rq.first_month  = fm;
        rq.first_day    = fd;
        rq.second_year  = sy;
        rq.second_month = sm;
        rq.second_day   = sd;
        rq.day_count    = cnt;
        request_q.push_back(rq);
    endfunction

    // mostly sensible years, with edges and the full field width mixed in
    function automatic logic [YEAR_W-1:0] pick_year();
        logic [YEAR_W-1:0] y;
        case ($urandom_range(0, 3))
            0: y = YEAR_W'($urandom);
            1: y = YEAR_W'($urandom_range(0, MAX_YEAR));
            2: y = $urandom_range(0, 1) ? YEAR_W'($urandom_range(0, 3))
                                        : YEAR_W'($urandom_range(MAX_YEAR - 9, MAX_YEAR));
            default: y = YEAR_W'($urandom_range(1890, 2110));
        endcase
        return y;
    endfunction

    function automatic logic [MONTH_W-1:0] pick_month();
        return ($urandom_range(0, 4) == 0) ? MONTH_W'($urandom_range(0, 15))
                                           : MONTH_W'($urandom_range(1, 12));
    endfunction

    function automatic logic [DAY_W-1:0] pick_day();
        return ($urandom_range(0, 4) == 0) ? DAY_W'($urandom_range(0, 31))
                                           : DAY_W'($urandom_range(1, 28));
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // item driver: bursts of items with random gaps between them
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            gap_left   = 0;
            burst_left = $urandom_range(1, 6);
        end else begin
            if (s_valid && s_ready) begin
                awaited_dates.push_back(engine_answer(drive_item));
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    drive_item = request_q.pop_front();
                    s_op           <= drive_item.op;
                    s_first_year   <= drive_item.first_year;
                    s_first_month  <= drive_item.first_month;
                    s_first_day    <= drive_item.first_day;
                    s_second_year  <= drive_item.second_year;
                    s_second_month <= drive_item.second_month;
                    s_second_day   <= drive_item.second_day;
                    s_day_count    <= drive_item.day_count;
                    s_valid        <= 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 6);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with its own stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                date_result_t exp_r;
                if (awaited_dates.size() == 0) begin
                    $error("result item arrived with nothing pending");
                    fail_count++;
                end else begin
                    exp_r = awaited_dates.pop_front();
                    check_field("result_year", exp_r.year, m_result_year);
                    check_field("result_month", exp_r.month, m_result_month);
                    check_field("result_day", exp_r.day, m_result_day);
                    check_field("day_difference", $signed(exp_r.diff), m_day_difference);
                    check_field("is_less", exp_r.less, m_is_less);
                    check_field("is_equal", exp_r.equal, m_is_equal);
                    check_field("out_of_range", exp_r.range_err, m_out_of_range);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (ready_left > 0) begin
                    ready_left--;
                end else begin
                    ready_left = $urandom_range(0, 12);
                    stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin
        logic [OP_W-1:0]           op;
        logic [YEAR_W-1:0]         fy;
        logic [MONTH_W-1:0]        fm;
        logic [DAY_W-1:0]          fd;
        logic [YEAR_W-1:0]         sy;
        logic [MONTH_W-1:0]        sm;
        logic [DAY_W-1:0]          sd;
        logic signed [COUNT_W-1:0] cnt;

        // directed: leap rules, range limits, sign swap, odd months and days
        add_request(OP_ADD, 14'd0, 4'd1, 5'd1, 14'd0, 4'd1, 5'd1, 16'sd0);
        add_request(OP_ADD, 14'd2024, 4'd2, 5'd28, 14'd0, 4'd0, 5'd0, 16'sd1);
        add_request(OP_ADD, 14'd1900, 4'd2, 5'd28, 14'd0, 4'd0, 5'd0, 16'sd1);
        add_request(OP_ADD, 14'd2000, 4'd2, 5'd28, 14'd0, 4'd0, 5'd0, 16'sd1);
        add_request(OP_ADD, 14'd9999, 4'd12, 5'd31, 14'd0, 4'd0, 5'd0, 16'sd1);
        add_request(OP_SUB, 14'd0, 4'd1, 5'd1, 14'd0, 4'd0, 5'd0, 16'sd1);
        add_request(OP_SUB, 14'd2024, 4'd3, 5'd1, 14'd0, 4'd0, 5'd0, 16'sd1);
        add_request(OP_ADD, 14'd2000, 4'd1, 5'd1, 14'd0, 4'd0, 5'd0, -16'sd32768);
        add_request(OP_SUB, 14'd2000, 4'd1, 5'd1, 14'd0, 4'd0, 5'd0, -16'sd32768);
        add_request(OP_SUB, 14'h3FFF, 4'hF, 5'h1F, 14'h3FFF, 4'hF, 5'h1F, 16'sd32767);
        add_request(OP_ADD, 14'd9000, 4'd1, 5'd1, 14'd0, 4'd0, 5'd0, 16'sd32767);
        add_request(OP_ADD, 14'd2023, 4'd0, 5'd0, 14'd0, 4'd0, 5'd0, 16'sd0);
        add_request(OP_ADD, 14'd2023, 4'd15, 5'd31, 14'd0, 4'd0, 5'd0, 16'sd0);
        add_request(OP_ADD, 14'd2023, 4'd2, 5'd30, 14'd0, 4'd0, 5'd0, 16'sd0);
        add_request(OP_DIFF, 14'h3FFF, 4'd12, 5'd31, 14'd0, 4'd1, 5'd1, 16'sd0);
        add_request(OP_DIFF, 14'd0, 4'd1, 5'd1, 14'h3FFF, 4'd12, 5'd31, 16'sd0);
        add_request(OP_DIFF, 14'd2024, 4'd3, 5'd1, 14'd2024, 4'd2, 5'd28, 16'sd0);
        add_request(OP_DIFF, 14'd1999, 4'd5, 5'd5, 14'd1999, 4'd5, 5'd5, 16'sd0);
        add_request(OP_DIFF, 14'd2010, 4'd0, 5'd0, 14'd2009, 4'd15, 5'd31, -16'sd1);
        add_request(OP_CMP, 14'd2020, 4'd6, 5'd15, 14'd2020, 4'd6, 5'd15, 16'sd0);
        add_request(OP_CMP, 14'd2019, 4'd12, 5'd31, 14'd2020, 4'd1, 5'd1, 16'sd0);
        add_request(OP_CMP, 14'd2020, 4'd0, 5'd31, 14'd2020, 4'd15, 5'd0, 16'sd0);
        add_request(OP_CMP, 14'd2020, 4'd6, 5'd0, 14'd2020, 4'd6, 5'd31, 16'sd0);
        add_request(OP_CMP, 14'h3FFF, 4'd1, 5'd1, 14'd0, 4'd12, 5'd31, 16'sd0);

        // random requests
        repeat (RANDOM_ITEMS) begin
            op = OP_W'($urandom_range(0, 3));
            fy = pick_year();
            fm = pick_month();
            fd = pick_day();
            sy = pick_year();
            sm = pick_month();
            sd = pick_day();
            case ($urandom_range(0, 3))
                0: begin
                    cnt = COUNT_W'($urandom_range(0, 60));
                    cnt = cnt - 16'sd30;
                end
                1: cnt = COUNT_W'($urandom);
                2: begin
                    case ($urandom_range(0, 4))
                        0: cnt = -16'sd32768;
                        1: cnt = 16'sd32767;
                        2: cnt = -16'sd1;
                        3: cnt = 16'sd1;
                        default: cnt = 16'sd0;
                    endcase
                end
                default: begin
                    cnt = COUNT_W'($urandom_range(0, 2000));
                    cnt = cnt - 16'sd1000;
                end
            endcase
            // second date close to the first, to reach the finer compare steps
            if (op == OP_CMP || op == OP_DIFF) begin
                case ($urandom_range(0, 3))
                    0: begin
                        sy = fy;
                        sm = fm;
                        sd = fd;
                    end
                    1: begin
                        sy = fy;
                        sm = fm;
                    end
                    2: sy = fy;
                    default: ;
                endcase
            end
            add_request(op, fy, fm, fd, sy, sm, sd, cnt);
        end
        total_requests = request_q.size();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_count < total_requests) @(posedge aclk);
        while (awaited_dates.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
